// ===== rtl/ingress_source_nat_filter_assert.svh =====
// Assertion macros for the ingress source-NAT filter.
// Included by the top level; no other dependencies.
`ifndef INGRESS_SOURCE_NAT_FILTER_ASSERT_SVH
`define INGRESS_SOURCE_NAT_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define ISNF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("isnf check failed: same-cycle implication");
`define ISNF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("isnf check failed: next-cycle implication");
`else
`define ISNF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ISNF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/isnf_pkg.sv =====
// Shared types and codes for the ingress source-NAT filter.
// No dependencies.
`timescale 1ns / 1ps
package isnf_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned BytesW  = 4;
  localparam int unsigned ReasonW = 3;
  localparam int unsigned IpW     = 32;
  localparam int unsigned MacW    = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PosW    = 6;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SENTRY_IP   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GATEWAY_IP  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ROUTER_MAC  = 2'd2;

  // frame kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_ARP     = 2'd1;
  localparam logic [1:0] KIND_IPV4    = 2'd2;
  localparam logic [1:0] KIND_OTHER   = 2'd3;

  // drop reasons
  localparam logic [ReasonW-1:0] RSN_NONE   = 3'd0;
  localparam logic [ReasonW-1:0] RSN_SHORT  = 3'd1;
  localparam logic [ReasonW-1:0] RSN_GROUP  = 3'd2;
  localparam logic [ReasonW-1:0] RSN_PROTO  = 3'd3;
  localparam logic [ReasonW-1:0] RSN_FRAG   = 3'd4;
  localparam logic [ReasonW-1:0] RSN_SENDER = 3'd5;

  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
  localparam logic [15:0] FRAG_MASK   = 16'h3FFF;

  localparam logic [PosW-1:0] POS_MAX   = 6'd63;
  localparam logic [PosW-1:0] LEN_ETH   = 6'd14;
  localparam logic [PosW-1:0] LEN_IPV4  = 6'd34;
  localparam logic [PosW-1:0] LEN_ARP   = 6'd42;
  localparam logic [BytesW-1:0] BEAT_BYTES = 4'd8;

  typedef struct packed {
    logic [DataW-1:0]  data;
    logic [BytesW-1:0] bytes;
    logic              last;
  } isnf_beat_t;

  typedef struct packed {
    logic [DataW-1:0]   data;
    logic [BytesW-1:0]  bytes;
    logic               last;
    logic               drop;
    logic [ReasonW-1:0] reason;
  } isnf_res_t;

  typedef struct packed {
    logic [IpW-1:0]  sentry_ip;
    logic [IpW-1:0]  gateway_ip;
    logic [MacW-1:0] router_mac;
  } isnf_cfg_t;

  typedef struct packed {
    logic [PosW-1:0]    pos;
    logic [1:0]         kind;
    logic               reply;
    logic [ReasonW-1:0] reason;
  } isnf_frame_t;

endpackage

// ===== rtl/isnf_in_reg.sv =====
// Input beat register with valid/ready handshake.
// Depends on isnf_pkg.
`timescale 1ns / 1ps
module isnf_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  isnf_pkg::isnf_beat_t in_beat,
  input  logic                 take,
  output logic                 st_valid,
  output isnf_pkg::isnf_beat_t st_beat
);
  import isnf_pkg::*;

  logic       valid_r, valid_nxt;
  isnf_beat_t beat_r;
  logic       load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= in_beat;
    end
  end

  assign st_valid = valid_r;
  assign st_beat  = beat_r;

endmodule

// ===== rtl/isnf_rewrite.sv =====
// Per-beat header rewrite, checksum patch and verdict, with frame tracking state.
// Depends on isnf_pkg.
`timescale 1ns / 1ps
module isnf_rewrite (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  isnf_pkg::isnf_cfg_t  cfg,
  input  isnf_pkg::isnf_beat_t beat,
  output isnf_pkg::isnf_res_t  res
);
  import isnf_pkg::*;

  isnf_frame_t        st_r, st_nxt;
  logic [2:0]         beat_idx;
  logic [DataW-1:0]   d, o;
  logic [15:0]        word;
  logic [1:0]         kind_n;
  logic               reply_n;
  logic [ReasonW-1:0] rsn_n;
  logic [ReasonW-1:0] note;
  logic [18:0]        csum;
  logic [16:0]        fold1;
  logic [15:0]        fold2;
  logic [BytesW-1:0]  valid_cnt;
  logic [PosW:0]      len_raw;
  logic [PosW-1:0]    len;
  logic [PosW:0]      pos_add;
  logic [ReasonW-1:0] verdict;

  assign beat_idx = st_r.pos[PosW-1:3];
  assign d        = beat.data;
  assign word     = d[31:16];

  // incremental checksum: ~(~hc + ~old + new), folded twice
  always_comb begin
    csum  = {3'b0, ~d[63:48]}
          + {3'b0, ~cfg.sentry_ip[31:16]}
          + {3'b0, ~cfg.sentry_ip[15:0]}
          + {3'b0, cfg.gateway_ip[31:16]}
          + {3'b0, cfg.gateway_ip[15:0]};
    fold1 = {1'b0, csum[15:0]} + {14'b0, csum[18:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};
  end

  always_comb begin
    o       = d;
    kind_n  = st_r.kind;
    reply_n = st_r.reply;
    note    = RSN_NONE;
    case (beat_idx)
      3'd0: begin
        if (d[56]) note = RSN_GROUP;
        o[15:0] = cfg.router_mac[47:32];
      end
      3'd1: begin
        o[63:32] = cfg.router_mac[31:0];
        if (word == ETYPE_ARP) begin
          kind_n = KIND_ARP;
        end else if (word == ETYPE_IPV4) begin
          kind_n = KIND_IPV4;
        end else begin
          kind_n = KIND_OTHER;
          note   = RSN_PROTO;
        end
      end
      3'd2: begin
        if (st_r.kind == KIND_ARP) begin
          reply_n = (word == ARP_OP_REPLY);
          if (reply_n) o[15:0] = cfg.router_mac[47:32];
        end else if (st_r.kind == KIND_IPV4) begin
          if ((word & FRAG_MASK) != 16'd0) note = RSN_FRAG;
        end
      end
      3'd3: begin
        if (st_r.kind == KIND_ARP) begin
          if (st_r.reply) o[63:32] = cfg.router_mac[31:0];
          if (d[31:0] != cfg.sentry_ip) note = RSN_SENDER;
          o[31:0] = cfg.gateway_ip;
        end else if (st_r.kind == KIND_IPV4) begin
          o[63:48] = ~fold2;
          if (d[47:16] != cfg.sentry_ip) note = RSN_SENDER;
          o[47:16] = cfg.gateway_ip;
        end
      end
      default: ;
    endcase
    // first reason sticks
    rsn_n = (st_r.reason == RSN_NONE) ? note : st_r.reason;
  end

  // verdict on the last beat
  always_comb begin
    valid_cnt = (beat.bytes > BEAT_BYTES) ? BEAT_BYTES : beat.bytes;
    len_raw   = {1'b0, st_r.pos} + {3'b0, valid_cnt};
    len       = (len_raw > {1'b0, POS_MAX}) ? POS_MAX : len_raw[PosW-1:0];
    if (len < LEN_ETH) begin
      verdict = RSN_SHORT;
    end else if (rsn_n == RSN_GROUP) begin
      verdict = RSN_GROUP;
    end else if (kind_n == KIND_ARP) begin
      verdict = (len < LEN_ARP) ? RSN_SHORT : rsn_n;
    end else if (kind_n == KIND_IPV4) begin
      verdict = (len < LEN_IPV4) ? RSN_SHORT : rsn_n;
    end else begin
      verdict = RSN_PROTO;
    end
  end

  always_comb begin
    pos_add = {1'b0, st_r.pos} + 7'd8;
    if (beat.last) begin
      st_nxt = '0;
    end else begin
      st_nxt.pos    = (pos_add > {1'b0, POS_MAX}) ? POS_MAX : pos_add[PosW-1:0];
      st_nxt.kind   = kind_n;
      st_nxt.reply  = reply_n;
      st_nxt.reason = rsn_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  assign res.data   = o;
  assign res.bytes  = beat.bytes;
  assign res.last   = beat.last;
  assign res.drop   = beat.last && (verdict != RSN_NONE);
  assign res.reason = beat.last ? verdict : RSN_NONE;

endmodule

// ===== rtl/isnf_out_reg.sv =====
// Result register driving the output channel.
// Depends on isnf_pkg.
`timescale 1ns / 1ps
module isnf_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  isnf_pkg::isnf_res_t res_in,
  output logic                out_valid,
  input  logic                out_ready,
  output isnf_pkg::isnf_res_t res_out
);
  import isnf_pkg::*;

  logic      valid_r, valid_nxt;
  isnf_res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== rtl/ingress_source_nat_filter.sv =====
// Ingress source-NAT filter: beats pass one input register, one rewrite pass, one result register.
// Depends on isnf_pkg, isnf_in_reg, isnf_rewrite, isnf_out_reg and the assertion header.
// The block takes one 64-bit beat per cycle unless out_ready holds the output, passes it through
// the input and result registers and rewrites the source MAC, ARP sender fields or IPv4 source
// address and checksum; throughput is one beat per cycle when not stalled, set by the single
// rewrite pass between the registers. The verdict appears with the last beat. Configuration writes
// take effect on the next cycle and are meant to happen between frames while no beat is in flight.
`timescale 1ns / 1ps
`include "ingress_source_nat_filter_assert.svh"
module ingress_source_nat_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [isnf_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [isnf_pkg::MacW-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [isnf_pkg::DataW-1:0]         in_beat_data,
  input  logic [isnf_pkg::BytesW-1:0]        in_beat_bytes,
  input  logic                               in_beat_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [isnf_pkg::DataW-1:0]         out_data,
  output logic [isnf_pkg::BytesW-1:0]        out_bytes,
  output logic                               out_last,
  output logic                               out_drop_frame,
  output logic [isnf_pkg::ReasonW-1:0]       out_drop_reason
);
  import isnf_pkg::*;

  isnf_cfg_t  cfg_r;
  isnf_beat_t in_beat, st_beat;
  isnf_res_t  res_c, res_q;
  logic       st_valid;
  logic       proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENTRY_IP:   cfg_r.sentry_ip   <= cfg_data[IpW-1:0];
        REG_GATEWAY_IP:  cfg_r.gateway_ip  <= cfg_data[IpW-1:0];
        REG_ROUTER_MAC:  cfg_r.router_mac  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_beat.data  = in_beat_data;
  assign in_beat.bytes = in_beat_bytes;
  assign in_beat.last  = in_beat_last;

  // move a beat into the result register when it is empty or draining
  assign proc_fire = st_valid && (!out_valid || out_ready);

  isnf_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .take     (proc_fire),
    .st_valid (st_valid),
    .st_beat  (st_beat)
  );

  isnf_rewrite u_rewrite (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (proc_fire),
    .cfg   (cfg_r),
    .beat  (st_beat),
    .res   (res_c)
  );

  isnf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_fire),
    .res_in    (res_c),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_data        = res_q.data;
  assign out_bytes       = res_q.bytes;
  assign out_last        = res_q.last;
  assign out_drop_frame  = res_q.drop;
  assign out_drop_reason = res_q.reason;

  `ISNF_ASSERT_IMP(a_no_verdict_mid, clk, rst_n, out_valid && !out_last, !out_drop_frame && (out_drop_reason == RSN_NONE))
  `ISNF_ASSERT_IMP(a_drop_has_reason, clk, rst_n, out_valid && out_last, out_drop_frame == (out_drop_reason != RSN_NONE))
  `ISNF_ASSERT_IMP(a_reason_range, clk, rst_n, out_valid, out_drop_reason <= RSN_SENDER)
  `ISNF_ASSERT_NXT(a_fire_fills_out, clk, rst_n, proc_fire, out_valid)

endmodule
